### rtl/core/tksd_pkg.sv
package tksd_pkg;

  localparam int unsigned SeqMaxLen = 8;

  typedef enum logic [1:0] {
    ACT_BYTE  = 2'd0,
    ACT_POLL  = 2'd1,
    ACT_WRITE = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    KIND_CHAR  = 3'd0,
    KIND_CTRL  = 3'd1,
    KIND_BKSP  = 3'd2,
    KIND_ESC   = 3'd3,
    KIND_MATCH = 3'd4
  } kind_t;

  localparam logic [7:0] CHAR_ESC = 8'd27;
  localparam logic [7:0] CHAR_DEL = 8'd127;
  localparam logic [7:0] CHAR_LBR = 8'h5B;
  localparam logic [7:0] CHAR_O   = 8'h4F;
  localparam logic [7:0] CHAR_A   = 8'h41;

  typedef struct packed {
    logic [3:0]  len;
    logic [63:0] text;
  } seq_entry_t;

  function automatic seq_entry_t mk(input logic [3:0] len, input logic [63:0] s);
    seq_entry_t e;
    e.len  = len;
    e.text = s;
    return e;
  endfunction

  function automatic seq_entry_t seq_rom(input logic [5:0] i);
    seq_entry_t e;
    e = mk(4'd0, 64'd0);
    case (i)
      6'd0:  e = mk(4'd3, {"O2P", 40'd0});
      6'd1:  e = mk(4'd3, {"O2Q", 40'd0});
      6'd2:  e = mk(4'd3, {"O2R", 40'd0});
      6'd3:  e = mk(4'd3, {"O2S", 40'd0});
      6'd4:  e = mk(4'd2, {"OM", 48'd0});
      6'd5:  e = mk(4'd2, {"OP", 48'd0});
      6'd6:  e = mk(4'd2, {"OQ", 48'd0});
      6'd7:  e = mk(4'd2, {"OR", 48'd0});
      6'd8:  e = mk(4'd2, {"OS", 48'd0});
      6'd9:  e = mk(4'd6, {"[15;2~", 16'd0});
      6'd10: e = mk(4'd4, {"[15~", 32'd0});
      6'd11: e = mk(4'd6, {"[17;2~", 16'd0});
      6'd12: e = mk(4'd4, {"[17~", 32'd0});
      6'd13: e = mk(4'd6, {"[18;2~", 16'd0});
      6'd14: e = mk(4'd4, {"[18~", 32'd0});
      6'd15: e = mk(4'd6, {"[19;2~", 16'd0});
      6'd16: e = mk(4'd4, {"[19~", 32'd0});
      6'd17: e = mk(4'd5, {"[1;5A", 24'd0});
      6'd18: e = mk(4'd5, {"[1;5B", 24'd0});
      6'd19: e = mk(4'd5, {"[1;5C", 24'd0});
      6'd20: e = mk(4'd5, {"[1;5D", 24'd0});
      6'd21: e = mk(4'd5, {"[1;5F", 24'd0});
      6'd22: e = mk(4'd5, {"[1;5H", 24'd0});
      6'd23: e = mk(4'd3, {"[1~", 40'd0});
      6'd24: e = mk(4'd6, {"[20;2~", 16'd0});
      6'd25: e = mk(4'd4, {"[20~", 32'd0});
      6'd26: e = mk(4'd6, {"[21;2~", 16'd0});
      6'd27: e = mk(4'd4, {"[21~", 32'd0});
      6'd28: e = mk(4'd6, {"[23;2~", 16'd0});
      6'd29: e = mk(4'd4, {"[23~", 32'd0});
      6'd30: e = mk(4'd6, {"[24;2~", 16'd0});
      6'd31: e = mk(4'd4, {"[24~", 32'd0});
      6'd32: e = mk(4'd5, {"[2;5~", 24'd0});
      6'd33: e = mk(4'd3, {"[2~", 40'd0});
      6'd34: e = mk(4'd5, {"[3;5~", 24'd0});
      6'd35: e = mk(4'd3, {"[3~", 40'd0});
      6'd36: e = mk(4'd3, {"[4~", 40'd0});
      6'd37: e = mk(4'd5, {"[5;5~", 24'd0});
      6'd38: e = mk(4'd3, {"[5~", 40'd0});
      6'd39: e = mk(4'd5, {"[6;5~", 24'd0});
      6'd40: e = mk(4'd3, {"[6~", 40'd0});
      6'd41: e = mk(4'd2, {"[A", 48'd0});
      6'd42: e = mk(4'd2, {"[B", 48'd0});
      6'd43: e = mk(4'd2, {"[C", 48'd0});
      6'd44: e = mk(4'd2, {"[D", 48'd0});
      6'd45: e = mk(4'd2, {"[F", 48'd0});
      6'd46: e = mk(4'd2, {"[H", 48'd0});
      6'd47: e = mk(4'd2, {"[Z", 48'd0});
      6'd48: e = mk(4'd3, {"[[A", 40'd0});
      6'd49: e = mk(4'd3, {"[[B", 40'd0});
      6'd50: e = mk(4'd3, {"[[C", 40'd0});
      6'd51: e = mk(4'd3, {"[[D", 40'd0});
      6'd52: e = mk(4'd3, {"[[E", 40'd0});
      default: e = mk(4'd0, 64'd0);
    endcase
    return e;
  endfunction

endpackage

### rtl/core/tksd_xlat_ram.sv
module tksd_xlat_ram import tksd_pkg::*; (
  input  logic       clk,
  input  logic       we,
  input  logic [7:0] waddr,
  input  logic [7:0] wdata,
  input  logic [7:0] raddr,
  output logic [7:0] rdata
);

  logic [7:0] mem [256];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/terminal_key_sequence_decoder_top.sv
// Flow: a raw byte passes through the states READ (translation table read),
// PROC and OUT; a poll or a decoded UTF-8 byte skips READ. When a sequence
// ends, SEARCH scans the sequence table entries (up to SEQ_TABLE_ENTRIES).
// Throughput: one word at a time; the sequence search walks the table one
// entry per cycle.
// Reset: rst is synchronous and active high; it returns the decoder to idle
// and clears the enable register. The translation table is not cleared.
module terminal_key_sequence_decoder_top import tksd_pkg::*; #(
  parameter int unsigned SEQ_TABLE_ENTRIES = 53,
  parameter int unsigned SEQ_BUFFER_LEN    = 13
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] action,
  input  logic [7:0] data_byte,
  input  logic [7:0] table_index,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] result_kind,
  output logic [7:0] char_value,
  output logic [5:0] sequence_index,
  output logic       last_result
);

  localparam int unsigned CntW = $clog2(SEQ_BUFFER_LEN + 1);
  localparam int unsigned BufW = $clog2(SEQ_BUFFER_LEN);

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_PROC, S_SEARCH, S_OUT
  } state_t;

  state_t           state;
  logic             utf8_en;
  logic [1:0]       esc;
  logic [CntW-1:0]  cnt;
  logic [7:0]       seq_buf [SEQ_BUFFER_LEN];
  logic [4:0]       lead;
  logic [7:0]       ch;
  logic             use_ram;
  logic             is_poll;
  logic [5:0]       scan;
  logic [2:0]       q_kind [2];
  logic [7:0]       q_char [2];
  logic [5:0]       q_idx  [2];
  logic [1:0]       q_n;
  logic             q_rd;
  logic [7:0]       ram_rdata;
  logic [7:0]       pch;
  logic             ram_we;
  logic [7:0]       byte_q;
  seq_entry_t       ent;
  logic             ent_hit;

  assign cfg_ready = (state == S_IDLE);
  assign in_stall  = (state != S_IDLE);
  assign ram_we    = in_valid && !in_stall && (action_t'(action) == ACT_WRITE);

  tksd_xlat_ram u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (table_index),
    .wdata (data_byte),
    .raddr (byte_q),
    .rdata (ram_rdata)
  );

  assign pch = use_ram ? ram_rdata : ch;
  assign ent = seq_rom(scan);

  always_comb begin
    ent_hit = ({28'd0, ent.len} == 32'(cnt)) && (32'(scan) < SEQ_TABLE_ENTRIES);
    for (int j = 0; j < SeqMaxLen; j++) begin
      if (j < SEQ_BUFFER_LEN && 32'(j) < 32'(cnt)) begin
        if (ent.text[63-8*j -: 8] != seq_buf[j]) begin
          ent_hit = 1'b0;
        end
      end
    end
  end

  assign out_valid      = (state == S_OUT);
  assign result_kind    = q_kind[q_rd];
  assign char_value     = q_char[q_rd];
  assign sequence_index = q_idx[q_rd];
  assign last_result    = (q_n == 2'd1) || q_rd;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      utf8_en <= 1'b0;
      esc     <= 2'd0;
      cnt     <= '0;
      lead    <= 5'd0;
      q_n     <= 2'd0;
      q_rd    <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cfg_valid) begin
            utf8_en <= cfg_data;
          end
          q_n  <= 2'd0;
          q_rd <= 1'b0;
          if (in_valid) begin
            is_poll <= 1'b0;
            use_ram <= 1'b0;
            ch      <= 8'd0;
            case (action_t'(action))
              ACT_POLL: begin
                is_poll <= 1'b1;
                state   <= S_PROC;
              end
              ACT_BYTE: begin
                if (utf8_en && data_byte[7]) begin
                  if (data_byte[6]) begin
                    lead <= (data_byte < 8'hE0) ? data_byte[4:0] : 5'd0;
                  end else if (lead != 5'd0) begin
                    lead <= 5'd0;
                    if (lead[4:2] == 3'd0) begin
                      ch    <= {lead[1:0], data_byte[5:0]};
                      state <= S_PROC;
                    end
                  end
                end else begin
                  byte_q  <= data_byte;
                  use_ram <= 1'b1;
                  state   <= S_READ;
                end
              end
              default: ;
            endcase
          end
        end
        S_READ: state <= S_PROC;
        S_PROC: begin
          use_ram <= 1'b0;
          ch      <= pch;
          state   <= S_OUT;
          if (is_poll || pch == 8'd0) begin
            if (esc == 2'd1) begin
              esc       <= 2'd0;
              q_kind[0] <= KIND_ESC;
              q_char[0] <= 8'd0;
              q_idx[0]  <= 6'd0;
              q_n       <= 2'd1;
            end else begin
              state <= S_IDLE;
            end
          end else if (esc == 2'd0) begin
            q_char[0] <= 8'd0;
            q_idx[0]  <= 6'd0;
            q_n       <= 2'd1;
            if (pch == CHAR_DEL) begin
              q_kind[0] <= KIND_BKSP;
            end else if (pch >= 8'h20) begin
              q_kind[0] <= KIND_CHAR;
              q_char[0] <= pch;
            end else if (pch >= 8'd1 && pch <= 8'd26) begin
              q_kind[0] <= KIND_CTRL;
              q_char[0] <= pch;
            end else begin
              q_n   <= 2'd0;
              state <= S_IDLE;
              if (pch == CHAR_ESC) begin
                esc <= 2'd1;
              end
            end
          end else if (esc == 2'd1) begin
            if (pch != CHAR_LBR && pch != CHAR_O) begin
              q_kind[0] <= KIND_ESC;
              q_char[0] <= 8'd0;
              q_idx[0]  <= 6'd0;
              q_n       <= 2'd1;
              q_kind[1] <= KIND_CHAR;
              q_char[1] <= 8'd0;
              q_idx[1]  <= 6'd0;
              esc       <= 2'd0;
              if (pch == CHAR_DEL) begin
                q_kind[1] <= KIND_BKSP;
                q_n       <= 2'd2;
              end else if (pch >= 8'h20) begin
                q_char[1] <= pch;
                q_n       <= 2'd2;
              end else if (pch >= 8'd1 && pch <= 8'd26) begin
                q_kind[1] <= KIND_CTRL;
                q_char[1] <= pch;
                q_n       <= 2'd2;
              end else if (pch == CHAR_ESC) begin
                esc <= 2'd1;
              end
            end else begin
              seq_buf[0] <= pch;
              cnt        <= CntW'(1);
              esc        <= 2'd2;
              state      <= S_IDLE;
            end
          end else begin
            if (32'(cnt) < SEQ_BUFFER_LEN) begin
              seq_buf[cnt[BufW-1:0]] <= pch;
              cnt <= cnt + CntW'(1);
            end
            if (pch < CHAR_A || pch == CHAR_LBR) begin
              state <= S_IDLE;
            end else begin
              esc   <= 2'd0;
              scan  <= 6'd0;
              state <= S_SEARCH;
            end
          end
        end
        S_SEARCH: begin
          if (ent_hit) begin
            q_kind[0] <= KIND_MATCH;
            q_char[0] <= 8'd0;
            q_idx[0]  <= scan;
            q_n       <= 2'd1;
            state     <= S_OUT;
          end else if (32'(scan) >= SEQ_TABLE_ENTRIES - 1 || scan == 6'd63) begin
            state <= S_IDLE;
          end else begin
            scan <= scan + 6'd1;
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            if (q_n == 2'd2 && !q_rd) begin
              q_rd <= 1'b1;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
